>>> src/assert_macros.svh
// Assertion macros used by the probation table sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define SWL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("probation table check failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define SWL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("probation table check failed");

`endif

>>> src/swlru_pkg.sv
// Shared constants, codes and types of the size-weighted LRU probation table.
package swlru_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int ACT_W   = 3;
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 16;
    localparam int HITS_W  = 16;
    localparam int TOT_W   = 32;
    localparam int STAT_W  = 2;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 152;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOOKUP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RETRIEVE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BIG  = 2'd2;

    // One table slot as held in the entry memory
    typedef struct packed {
        logic [IDX_W-1:0]  rank;
        logic [HITS_W-1:0] hits;
        logic [SIZE_W-1:0] size;
        logic [KEY_W-1:0]  key;
    } entry_t;

    // Sequencer to entry store
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             v_we;
        logic [IDX_W-1:0] v_addr;
        logic             v_set;
    } store_cmd_t;

    // Entry store to sequencer, in the cycle after a read
    typedef struct packed {
        entry_t word;
        logic   vld;
    } store_rsp_t;

    // One result word
    typedef struct packed {
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic [STAT_W-1:0] status;
        logic              hit;
        logic [HITS_W-1:0] hit_count;
        logic [TOT_W-1:0]  used_size;
        logic [TOT_W-1:0]  read_count;
        logic [TOT_W-1:0]  write_count;
        logic              last;
    } result_t;

endpackage

>>> src/swlru_store.sv
// Entry memory with registered read and per-slot valid flags.
module swlru_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swlru_pkg::store_cmd_t  cmd,
    output swlru_pkg::store_rsp_t  rsp
);
    import swlru_pkg::*;

    entry_t             mem [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    logic               rd_vld_reg;
    entry_t             rd_word_reg;

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_word_reg <= mem[cmd.rd_addr];
        end
    end

    // Hold slot valid flags; sample the flag of the slot being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.v_we)
            begin
                vld_reg[cmd.v_addr] <= cmd.v_set;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= vld_reg[cmd.rd_addr];
            end
        end
    end

    assign rsp.word = rd_word_reg;
    assign rsp.vld  = rd_vld_reg;

endmodule

>>> src/swlru_seq.sv
// Sequencer: sweeps the entry store with one shared compare/adjust unit.
`include "assert_macros.svh"

module swlru_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swlru_pkg::ACT_W-1:0]   in_action,
    input  logic [swlru_pkg::KEY_W-1:0]   in_key,
    input  logic [swlru_pkg::SIZE_W-1:0]  in_size,
    input  logic                          cap_we,
    input  logic [swlru_pkg::TOT_W-1:0]   cap_data,
    output swlru_pkg::store_cmd_t         st_cmd,
    input  swlru_pkg::store_rsp_t         st_rsp,
    output logic                          res_valid,
    input  logic                          res_ready,
    output swlru_pkg::result_t            res
);
    import swlru_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_REMOVE,
        ST_DEC,
        ST_EVCHK,
        ST_TAIL,
        ST_EVICT,
        ST_INS,
        ST_PLACE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t             state_reg,      state_next;
    logic [ACT_W-1:0]   act_reg,        act_next;
    logic [KEY_W-1:0]   key_reg,        key_next;
    logic [SIZE_W-1:0]  size_reg,       size_next;
    logic [TOT_W-1:0]   cap_reg,        cap_next;
    logic [TOT_W-1:0]   used_reg,       used_next;
    logic [TOT_W-1:0]   reads_reg,      reads_next;
    logic [TOT_W-1:0]   writes_reg,     writes_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [CNT_W-1:0]   sw_idx_reg,     sw_idx_next;
    logic               chk_reg,        chk_next;
    logic [IDX_W-1:0]   chk_idx_reg,    chk_idx_next;
    logic               s_found_reg,    s_found_next;
    logic [IDX_W-1:0]   s_idx_reg,      s_idx_next;
    entry_t             s_word_reg,     s_word_next;
    logic               t_found_reg,    t_found_next;
    logic [IDX_W-1:0]   t_idx_reg,      t_idx_next;
    entry_t             t_word_reg,     t_word_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg,   free_idx_next;
    logic [IDX_W-1:0]   r_reg,          r_next;
    logic               evicted_reg,    evicted_next;
    logic [KEY_W-1:0]   ekey_reg,       ekey_next;
    logic [STAT_W-1:0]  status_reg,     status_next;
    logic               hit_reg,        hit_next;
    logic [HITS_W-1:0]  hc_reg,         hc_next;
    logic               last_reg,       last_next;

    logic               sw_active;
    logic               issue;
    logic               sw_done;
    logic               is_head;
    logic [TOT_W:0]     need_sum;
    logic               over_cap;
    logic               too_large;
    logic [IDX_W-1:0]   tail_rank;
    entry_t             upd_word;

    // Shared unit: capacity compare for the pending insert
    always_comb
    begin
        is_head   = (act_reg == ACT_INS_HEAD);
        need_sum  = {1'b0, used_reg} + (TOT_W + 1)'(size_reg);
        over_cap  = is_head ? (need_sum >= {1'b0, cap_reg})
                            : (need_sum >  {1'b0, cap_reg});
        too_large = is_head ? (TOT_W'(size_reg) >= cap_reg)
                            : (TOT_W'(size_reg) >  cap_reg);
        tail_rank = IDX_W'(count_reg - CNT_W'(1));
    end

    // Sweep address generation
    always_comb
    begin
        sw_active = (state_reg == ST_SCAN) || (state_reg == ST_DEC) ||
                    (state_reg == ST_TAIL) || (state_reg == ST_INS);
        issue     = sw_active && (sw_idx_reg != CNT_W'(ENTRIES));
        sw_done   = sw_active && !issue && !chk_reg;
    end

    // Next-state and datapath
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        cap_next        = cap_we ? cap_data : cap_reg;
        used_next       = used_reg;
        reads_next      = reads_reg;
        writes_next     = writes_reg;
        count_next      = count_reg;
        sw_idx_next     = sw_idx_reg;
        chk_next        = chk_reg;
        chk_idx_next    = chk_idx_reg;
        s_found_next    = s_found_reg;
        s_idx_next      = s_idx_reg;
        s_word_next     = s_word_reg;
        t_found_next    = t_found_reg;
        t_idx_next      = t_idx_reg;
        t_word_next     = t_word_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        r_next          = r_reg;
        evicted_next    = evicted_reg;
        ekey_next       = ekey_reg;
        status_next     = status_reg;
        hit_next        = hit_reg;
        hc_next         = hc_reg;
        last_next       = last_reg;
        st_cmd          = '0;
        upd_word        = st_rsp.word;
        in_ready        = (state_reg == ST_IDLE);
        res_valid       = (state_reg == ST_EMIT);

        // Advance the sweep pointer and pipe the index to the compare stage
        st_cmd.rd_en   = issue;
        st_cmd.rd_addr = sw_idx_reg[IDX_W-1:0];
        if (sw_active)
        begin
            sw_idx_next  = issue ? sw_idx_reg + CNT_W'(1) : sw_idx_reg;
            chk_next     = issue;
            chk_idx_next = sw_idx_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = in_action;
                    key_next     = in_key;
                    size_next    = in_size;
                    evicted_next = 1'b0;
                    ekey_next    = '0;
                    status_next  = STAT_OK;
                    hit_next     = 1'b0;
                    hc_next      = '0;
                    last_next    = 1'b1;
                    sw_idx_next  = '0;
                    chk_next     = 1'b0;
                    s_found_next = 1'b0;
                    unique case (in_action) inside
                        ACT_INS_HEAD, ACT_INS_TAIL, ACT_DELETE, ACT_LOOKUP, ACT_RETRIEVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        ACT_CLEAR:
                        begin
                            reads_next  = '0;
                            writes_next = '0;
                            state_next  = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Match the key against each valid slot
                if (chk_reg && st_rsp.vld && !s_found_reg && (st_rsp.word.key == key_reg))
                begin
                    s_found_next = 1'b1;
                    s_idx_next   = chk_idx_reg;
                    s_word_next  = st_rsp.word;
                end
                if (sw_done)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                hit_next = s_found_reg;
                unique case (act_reg) inside
                    ACT_INS_HEAD, ACT_INS_TAIL:
                    begin
                        if (too_large)
                        begin
                            status_next = STAT_BIG;
                            state_next  = ST_EMIT;
                        end
                        else if (s_found_reg)
                        begin
                            state_next = ST_REMOVE;
                        end
                        else
                        begin
                            state_next = ST_EVCHK;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (s_found_reg)
                        begin
                            state_next = ST_REMOVE;
                        end
                        else
                        begin
                            status_next = STAT_MISS;
                            state_next  = ST_EMIT;
                        end
                    end
                    ACT_LOOKUP, ACT_RETRIEVE:
                    begin
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end

            ST_REMOVE:
            begin
                // Drop the matched slot, then close the gap in the ranks
                st_cmd.v_we   = 1'b1;
                st_cmd.v_addr = s_idx_reg;
                st_cmd.v_set  = 1'b0;
                count_next    = count_reg - CNT_W'(1);
                used_next     = used_reg - TOT_W'(s_word_reg.size);
                writes_next   = writes_reg + TOT_W'(1);
                r_next        = s_word_reg.rank;
                sw_idx_next   = '0;
                chk_next      = 1'b0;
                state_next    = ST_DEC;
            end

            ST_DEC:
            begin
                if (chk_reg && st_rsp.vld && (st_rsp.word.rank > r_reg))
                begin
                    upd_word.rank  = st_rsp.word.rank - IDX_W'(1);
                    st_cmd.wr_en   = 1'b1;
                    st_cmd.wr_addr = chk_idx_reg;
                    st_cmd.wr_data = upd_word;
                end
                if (sw_done)
                begin
                    if ((act_reg == ACT_INS_HEAD) || (act_reg == ACT_INS_TAIL))
                    begin
                        state_next = ST_EVCHK;
                    end
                    else
                    begin
                        status_next = STAT_OK;
                        state_next  = ST_EMIT;
                    end
                end
            end

            ST_EVCHK:
            begin
                sw_idx_next     = '0;
                chk_next        = 1'b0;
                t_found_next    = 1'b0;
                free_found_next = 1'b0;
                if (((count_reg != '0) && over_cap) || (count_reg == CNT_W'(ENTRIES)))
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    state_next = ST_INS;
                end
            end

            ST_TAIL:
            begin
                // Find the slot holding the oldest rank
                if (chk_reg && st_rsp.vld && (st_rsp.word.rank == tail_rank))
                begin
                    t_found_next = 1'b1;
                    t_idx_next   = chk_idx_reg;
                    t_word_next  = st_rsp.word;
                end
                if (sw_done)
                begin
                    state_next = ST_EVICT;
                end
            end

            ST_EVICT:
            begin
                st_cmd.v_we   = 1'b1;
                st_cmd.v_addr = t_idx_reg;
                st_cmd.v_set  = 1'b0;
                count_next    = count_reg - CNT_W'(1);
                used_next     = used_reg - TOT_W'(t_word_reg.size);
                writes_next   = writes_reg + TOT_W'(1);
                evicted_next  = 1'b1;
                ekey_next     = t_word_reg.key;
                last_next     = 1'b0;
                state_next    = ST_EMIT;
            end

            ST_INS:
            begin
                // Age every slot on a head insert; note the first free slot
                if (chk_reg)
                begin
                    if (st_rsp.vld)
                    begin
                        if (is_head)
                        begin
                            upd_word.rank  = st_rsp.word.rank + IDX_W'(1);
                            st_cmd.wr_en   = 1'b1;
                            st_cmd.wr_addr = chk_idx_reg;
                            st_cmd.wr_data = upd_word;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                if (sw_done)
                begin
                    state_next = ST_PLACE;
                end
            end

            ST_PLACE:
            begin
                upd_word.key   = key_reg;
                upd_word.size  = size_reg;
                upd_word.hits  = '0;
                upd_word.rank  = is_head ? '0 : IDX_W'(count_reg);
                st_cmd.wr_en   = 1'b1;
                st_cmd.wr_addr = free_idx_reg;
                st_cmd.wr_data = upd_word;
                st_cmd.v_we    = 1'b1;
                st_cmd.v_addr  = free_idx_reg;
                st_cmd.v_set   = 1'b1;
                count_next     = count_reg + CNT_W'(1);
                used_next      = used_reg + TOT_W'(size_reg);
                writes_next    = writes_reg + TOT_W'(1);
                status_next    = STAT_OK;
                state_next     = ST_EMIT;
            end

            ST_READ:
            begin
                reads_next = reads_reg + TOT_W'(1);
                if (s_found_reg)
                begin
                    status_next = STAT_OK;
                    hc_next     = s_word_reg.hits;
                    if ((act_reg == ACT_RETRIEVE) && (s_word_reg.hits != '1))
                    begin
                        upd_word       = s_word_reg;
                        upd_word.hits  = s_word_reg.hits + HITS_W'(1);
                        st_cmd.wr_en   = 1'b1;
                        st_cmd.wr_addr = s_idx_reg;
                        st_cmd.wr_data = upd_word;
                        hc_next        = upd_word.hits;
                    end
                end
                else
                begin
                    status_next = STAT_MISS;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (res_ready)
                begin
                    evicted_next = 1'b0;
                    ekey_next    = '0;
                    last_next    = 1'b1;
                    state_next   = last_reg ? ST_IDLE : ST_EVCHK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Present the pending result
    always_comb
    begin
        res.evicted     = evicted_reg;
        res.evicted_key = ekey_reg;
        res.status      = evicted_reg ? STAT_OK : status_reg;
        res.hit         = evicted_reg ? 1'b0 : hit_reg;
        res.hit_count   = evicted_reg ? '0 : hc_reg;
        res.used_size   = used_reg;
        res.read_count  = reads_reg;
        res.write_count = writes_reg;
        res.last        = last_reg;
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            act_reg        <= '0;
            key_reg        <= '0;
            size_reg       <= '0;
            cap_reg        <= '0;
            used_reg       <= '0;
            reads_reg      <= '0;
            writes_reg     <= '0;
            count_reg      <= '0;
            sw_idx_reg     <= '0;
            chk_reg        <= 1'b0;
            chk_idx_reg    <= '0;
            s_found_reg    <= 1'b0;
            s_idx_reg      <= '0;
            s_word_reg     <= '0;
            t_found_reg    <= 1'b0;
            t_idx_reg      <= '0;
            t_word_reg     <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            r_reg          <= '0;
            evicted_reg    <= 1'b0;
            ekey_reg       <= '0;
            status_reg     <= STAT_OK;
            hit_reg        <= 1'b0;
            hc_reg         <= '0;
            last_reg       <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            key_reg        <= key_next;
            size_reg       <= size_next;
            cap_reg        <= cap_next;
            used_reg       <= used_next;
            reads_reg      <= reads_next;
            writes_reg     <= writes_next;
            count_reg      <= count_next;
            sw_idx_reg     <= sw_idx_next;
            chk_reg        <= chk_next;
            chk_idx_reg    <= chk_idx_next;
            s_found_reg    <= s_found_next;
            s_idx_reg      <= s_idx_next;
            s_word_reg     <= s_word_next;
            t_found_reg    <= t_found_next;
            t_idx_reg      <= t_idx_next;
            t_word_reg     <= t_word_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            r_reg          <= r_next;
            evicted_reg    <= evicted_next;
            ekey_reg       <= ekey_next;
            status_reg     <= status_next;
            hit_reg        <= hit_next;
            hc_reg         <= hc_next;
            last_reg       <= last_next;
        end
    end

    // Slot count never passes the table depth
    `SWL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRIES))
    // An eviction always finds its tail slot and reports it next
    `SWL_ASSERT_IMP(a_tail_found, state_reg == ST_EVICT, t_found_reg && (count_reg != '0))
    `SWL_ASSERT_NXT(a_evict_emits, state_reg == ST_EVICT, state_reg == ST_EMIT && evicted_reg && !last_reg)
    // A new entry is only placed into a free slot
    `SWL_ASSERT_IMP(a_place_room, state_reg == ST_PLACE, free_found_reg && (count_reg < CNT_W'(ENTRIES)))

endmodule

>>> src/size_weighted_lru_probation_table.sv
// Top level: stream ports, output register and the sequencer/store pair.
// Time to the result word is set by the one-slot-per-cycle sweep of the entry memory:
// lookup, retrieve, delete and insert sweep it once, an insert that fits sweeps it again,
// each eviction adds a tail sweep and a replaced or deleted key adds a rank sweep;
// a stalled result side adds its stall. One item is in work at a time.
// Reset (rst_n low, asynchronous) empties the table and zeroes capacity and counters.
module size_weighted_lru_probation_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // segment_key[31:0], segment_size[47:32]
    input  logic [swlru_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action[2:0]
    input  logic [swlru_pkg::ACT_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // evicted_key[31:0], status[33:32], hit[34], hit_count[50:35],
    // used_size[82:51], read_count[114:83], write_count[146:115], zero fill
    output logic [swlru_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // evicted
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [swlru_pkg::TOT_W-1:0]        cfg_wdata
);
    import swlru_pkg::*;

    localparam int PAD_W = OUT_DATA_W - (KEY_W + STAT_W + 1 + HITS_W + 3 * TOT_W);

    store_cmd_t st_cmd;
    store_rsp_t st_rsp;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    result_t    out_reg;
    logic       out_valid_reg;

    swlru_store u_store (
        .clk (clk),
        .rst_n (rst_n),
        .cmd (st_cmd),
        .rsp (st_rsp)
    );

    swlru_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_key    (s_axis_tdata[KEY_W-1:0]),
        .in_size   (s_axis_tdata[KEY_W+SIZE_W-1:KEY_W]),
        .cap_we    (cfg_we),
        .cap_data  (cfg_wdata),
        .st_cmd    (st_cmd),
        .st_rsp    (st_rsp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a new result word while the slot is empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    // Pack the result word onto the master side
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.evicted;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_reg.write_count, out_reg.read_count,
                            out_reg.used_size, out_reg.hit_count, out_reg.hit,
                            out_reg.status, out_reg.evicted_key};

endmodule

>>> dv/swlru_checker.sv
// Checker for the probation table: watches both streams, predicts result words, compares.
`timescale 1ns / 1ps

module swlru_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [swlru_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [swlru_pkg::ACT_W-1:0]      s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [swlru_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             m_tuser,
    input  logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [swlru_pkg::TOT_W-1:0]      cfg_wdata,
    output int                               mismatches,
    output int                               pending
);
    import swlru_pkg::*;

    // Shadow copy of the table and its counters
    logic              tbl_valid [ENTRIES];
    logic [KEY_W-1:0]  tbl_key   [ENTRIES];
    logic [SIZE_W-1:0] tbl_size  [ENTRIES];
    logic [HITS_W-1:0] tbl_hits  [ENTRIES];
    int                tbl_rank  [ENTRIES];
    logic [TOT_W-1:0]  used_bytes;
    logic [TOT_W-1:0]  reads;
    logic [TOT_W-1:0]  writes;
    logic [TOT_W-1:0]  cap_bytes;

    // Result words still owed by the block, oldest first
    result_t           owed_words [$];

    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                n++;
        return n;
    endfunction

    function automatic int tail_slot();
        int n;
        n = live_count();
        if (n == 0)
            return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] == n - 1)
                return i;
        return -1;
    endfunction

    // Queue one expected word, stamped with the counters as they stand now
    task automatic owe_word(input logic ev, input logic [KEY_W-1:0] ekey,
                            input logic [STAT_W-1:0] st, input logic hit,
                            input logic [HITS_W-1:0] hc, input logic fin);
        result_t w;
        w.evicted     = ev;
        w.evicted_key = ekey;
        w.status      = st;
        w.hit         = hit;
        w.hit_count   = hc;
        w.used_size   = used_bytes;
        w.read_count  = reads;
        w.write_count = writes;
        w.last        = fin;
        owed_words.push_back(w);
    endtask

    // Unlink a slot, close the gap in the recency order
    task automatic drop_slot(input int s);
        tbl_valid[s] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] > tbl_rank[s])
                tbl_rank[i]--;
        used_bytes = used_bytes - {16'd0, tbl_size[s]};
        writes     = writes + TOT_W'(1);
    endtask

    task automatic evict_tail();
        int t;
        t = tail_slot();
        if (t >= 0)
        begin
            drop_slot(t);
            owe_word(1'b1, tbl_key[t], STAT_OK, 1'b0, '0, 1'b0);
        end
    endtask

    // Advance the shadow table by one request and queue its result words
    task automatic model_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                                 input logic [SIZE_W-1:0] sz);
        int         s;
        int         n;
        logic       present;
        logic       head;
        logic       too_big;
        logic [32:0] sum;
        logic [HITS_W-1:0] hc;
        s       = find_slot(key);
        present = (s >= 0);
        case (act) inside
            ACT_INS_HEAD, ACT_INS_TAIL:
            begin
                head    = (act == ACT_INS_HEAD);
                too_big = head ? ({16'd0, sz} >= cap_bytes) : ({16'd0, sz} > cap_bytes);
                if (too_big)
                    owe_word(1'b0, '0, STAT_BIG, present, '0, 1'b1);
                else
                begin
                    if (present)
                        drop_slot(s);
                    // Make room by size, then by slot count
                    forever
                    begin
                        sum = {1'b0, used_bytes} + {17'd0, sz};
                        if (live_count() == 0)
                            break;
                        if (head ? (sum < {1'b0, cap_bytes}) : (sum <= {1'b0, cap_bytes}))
                            break;
                        evict_tail();
                    end
                    if (live_count() >= ENTRIES)
                        evict_tail();
                    s = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!tbl_valid[i] && s < 0)
                            s = i;
                    if (s >= 0)
                    begin
                        n = live_count();
                        if (head)
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                                if (tbl_valid[i])
                                    tbl_rank[i]++;
                            tbl_rank[s] = 0;
                        end
                        else
                            tbl_rank[s] = n;
                        tbl_valid[s] = 1'b1;
                        tbl_key[s]   = key;
                        tbl_size[s]  = sz;
                        tbl_hits[s]  = '0;
                        used_bytes   = used_bytes + {16'd0, sz};
                        writes       = writes + TOT_W'(1);
                    end
                    owe_word(1'b0, '0, STAT_OK, present, '0, 1'b1);
                end
            end
            ACT_DELETE:
            begin
                if (present)
                    drop_slot(s);
                owe_word(1'b0, '0, present ? STAT_OK : STAT_MISS, present, '0, 1'b1);
            end
            ACT_LOOKUP, ACT_RETRIEVE:
            begin
                hc    = '0;
                reads = reads + TOT_W'(1);
                if (present)
                begin
                    if (act == ACT_RETRIEVE && tbl_hits[s] != '1)
                        tbl_hits[s] = tbl_hits[s] + HITS_W'(1);
                    hc = tbl_hits[s];
                end
                owe_word(1'b0, '0, present ? STAT_OK : STAT_MISS, present, hc, 1'b1);
            end
            ACT_CLEAR:
            begin
                reads  = '0;
                writes = '0;
                owe_word(1'b0, '0, STAT_OK, 1'b0, '0, 1'b1);
            end
            default:
                owe_word(1'b0, '0, STAT_OK, 1'b0, '0, 1'b1);
        endcase
    endtask

    task automatic check_field(input string name, input logic [TOT_W-1:0] e,
                               input logic [TOT_W-1:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            mismatches++;
        end
    endtask

    // Compare one output word with the oldest owed word
    task automatic compare_word();
        result_t e;
        if (owed_words.size() == 0)
        begin
            $error("result word with no expectation waiting: tdata %0h", m_tdata);
            mismatches++;
        end
        else
        begin
            e = owed_words.pop_front();
            check_field("evicted",     TOT_W'(e.evicted),   TOT_W'(m_tuser));
            check_field("evicted_key", e.evicted_key,       m_tdata[31:0]);
            check_field("status",      TOT_W'(e.status),    TOT_W'(m_tdata[33:32]));
            check_field("hit",         TOT_W'(e.hit),       TOT_W'(m_tdata[34]));
            check_field("hit_count",   TOT_W'(e.hit_count), TOT_W'(m_tdata[50:35]));
            check_field("used_size",   e.used_size,         m_tdata[82:51]);
            check_field("read_count",  e.read_count,        m_tdata[114:83]);
            check_field("write_count", e.write_count,       m_tdata[146:115]);
            check_field("last",        TOT_W'(e.last),      TOT_W'(m_tlast));
        end
    endtask

    // Track configuration, requests and results on each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tbl_valid[i] = 1'b0;
                tbl_rank[i]  = 0;
            end
            used_bytes = '0;
            reads      = '0;
            writes     = '0;
            cap_bytes  = '0;
            owed_words.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
                cap_bytes = cfg_wdata;
            if (s_tvalid && s_tready)
                model_request(s_tuser, s_tdata[31:0], s_tdata[47:32]);
            if (m_tvalid && m_tready)
                compare_word();
            pending = owed_words.size();
        end
    end

endmodule

>>> dv/tb_size_weighted_lru_probation_table.sv
// Testbench top for the probation table: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_size_weighted_lru_probation_table;
    import swlru_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int KEY_POOL    = 40;
    localparam int PHASES      = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [ACT_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [TOT_W-1:0]      cfg_wdata;
    int                    mismatches;
    int                    pending;

    // Turn off random gaps on one side for a stretch
    logic                  tx_eager;
    logic                  rx_eager;
    logic [KEY_W-1:0]      key_pool [KEY_POOL];

    size_weighted_lru_probation_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    swlru_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .m_tlast    (m_axis_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        for (int n = 0; n < CYCLE_LIMIT; n++)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Result side back-pressure: mostly short stalls, a few long ones
    initial
    begin
        int stall;
        int r;
        stall = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_eager)
            begin
                m_axis_tready <= 1'b1;
                stall = 0;
            end
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 55)
                    stall = 0;
                else if (r < 92)
                    stall = $urandom_range(1, 3);
                else
                    stall = $urandom_range(8, 40);
            end
        end
    end

    function automatic int tx_gap();
        int r;
        if (tx_eager)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one request word after a random gap, hold it until accepted
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                             input logic [SIZE_W-1:0] sz);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {sz, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every owed result word has come back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [TOT_W-1:0] value);
        drain();
        repeat (ENTRIES + 8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return SIZE_W'($urandom_range(1, 700));
        if (r < 75)
            return SIZE_W'($urandom_range(0, 40));
        if (r < 90)
            return SIZE_W'($urandom_range(0, 65535));
        if (r < 95)
            return '0;
        return '1;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return $urandom;
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input int ins_pct);
        int r;
        if ($urandom_range(0, 99) < ins_pct)
            return ($urandom_range(0, 99) < 60) ? ACT_INS_HEAD : ACT_INS_TAIL;
        r = $urandom_range(0, 99);
        if (r < 25)
            return ACT_DELETE;
        if (r < 50)
            return ACT_LOOKUP;
        if (r < 85)
            return ACT_RETRIEVE;
        if (r < 92)
            return ACT_CLEAR;
        return ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
    endfunction

    // Main stimulus
    initial
    begin
        logic [KEY_W-1:0] k_lo;
        logic [KEY_W-1:0] k_hi;
        logic [KEY_W-1:0] k_mid;
        logic [TOT_W-1:0] phase_cap [PHASES];
        int               phase_len [PHASES];
        int               phase_ins [PHASES];

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        tx_eager      = 1'b0;
        rx_eager      = 1'b0;
        k_lo  = '0;
        k_hi  = '1;
        k_mid = 32'h1234_5678;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        key_pool[0] = k_lo;
        key_pool[1] = k_hi;
        phase_cap = '{32'hFFFF_FFFF, 64, 6000, 200000, 0, 1500, 32'h8000_0000, 0};
        phase_cap[7] = $urandom_range(100, 30000);
        phase_len = '{56, 48, 48, 48, 40, 48, 48, 48};
        phase_ins = '{75, 45, 50, 50, 45, 50, 45, 50};

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Zero capacity: only a zero-size tail insert fits
        write_capacity(32'd0);
        send_item(ACT_INS_TAIL, k_lo, 16'd0);
        send_item(ACT_INS_HEAD, k_hi, 16'd0);
        send_item(ACT_LOOKUP,   k_lo, 16'd0);
        send_item(ACT_RETRIEVE, k_lo, 16'hFFFF);
        send_item(ACT_RETRIEVE, k_lo, 16'd0);
        send_item(ACT_LOOKUP,   k_mid, 16'd0);
        send_item(ACT_DELETE,   k_mid, 16'd0);
        send_item(ACT_SPARE_LO, k_hi, 16'hFFFF);
        send_item(ACT_SPARE_HI, k_lo, 16'd0);
        send_item(ACT_CLEAR,    k_hi, 16'hFFFF);

        // Capacity equal to the largest size: head rejects it, tail takes it
        write_capacity(32'd65535);
        send_item(ACT_INS_HEAD, k_hi, 16'hFFFF);
        send_item(ACT_INS_TAIL, k_hi, 16'hFFFF);
        send_item(ACT_INS_HEAD, k_mid, 16'd1);
        send_item(ACT_INS_TAIL, k_lo, 16'd300);
        send_item(ACT_RETRIEVE, k_mid, 16'd0);
        send_item(ACT_DELETE,   k_mid, 16'd0);
        send_item(ACT_DELETE,   k_mid, 16'd0);
        send_item(ACT_LOOKUP,   k_lo, 16'd0);

        // Largest capacity
        write_capacity(32'hFFFF_FFFF);
        send_item(ACT_INS_HEAD, k_hi, 16'hFFFF);
        send_item(ACT_INS_TAIL, k_mid, 16'hFFFF);
        send_item(ACT_RETRIEVE, k_hi, 16'd0);
        send_item(ACT_CLEAR,    k_lo, 16'd0);

        // Random phases, each under its own capacity
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_capacity(phase_cap[ph]);
            tx_eager = (ph % 3 == 2);
            rx_eager = (ph % 4 == 1);
            for (int i = 0; i < phase_len[ph]; i++)
                send_item(pick_action(phase_ins[ph]), pick_key(), pick_size());
        end

        // Wait out the last results, then give the verdict
        drain();
        repeat (3 * ENTRIES + 16) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/swlru_pkg.sv
src/swlru_store.sv
src/swlru_seq.sv
src/size_weighted_lru_probation_table.sv
dv/swlru_checker.sv
dv/tb_size_weighted_lru_probation_table.sv
